[hdl/sil_pkg.sv]
// ============================================================================
// sil_pkg: shared types and constants of the sorted insertion list
// Word layouts of the request and response channels, operation codes, list
// sizing and the controller state type.
// ============================================================================
package sil_pkg;

   // Number of entries the list can hold.
   localparam int LIST_DEPTH = 32;
   // Address width of the entry store.
   localparam int IDX_BITS   = $clog2(LIST_DEPTH);
   // Width of the entry count field.
   localparam int COUNT_BITS = 7;
   localparam int KEY_BITS   = 32;
   localparam int TAG_W      = 16;

   // Operation codes carried in the opcode field.
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DRAIN  = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   typedef struct packed {
      logic [1:0]                 opcode;
      logic signed [KEY_BITS-1:0] sort_key;
      logic [TAG_W-1:0]           entry_tag;
   } req_word_type;

   typedef struct packed {
      logic signed [KEY_BITS-1:0] out_key;
      logic [TAG_W-1:0]           out_tag;
      logic                       is_last;
      logic                       list_empty;
      logic                       overflow;
      logic [COUNT_BITS-1:0]      entry_count;
   } rsp_word_type;

   // One stored entry of the list.
   typedef struct packed {
      logic signed [KEY_BITS-1:0] key;
      logic [TAG_W-1:0]           tag;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_HEAD,
      ST_DRAIN,
      ST_REPLY
   } state_type;

endpackage

[hdl/sorted_insert_list_unit.sv]
// ============================================================================
// sorted_insert_list_unit: ascending-key priority list in a single RAM
// Holds (key, tag) entries sorted by signed Q16.16 key, newest first among
// equal keys. Supports insert, in-order drain and clear.
// ============================================================================
//
//   Channel   Direction   Word            Handshake
//   req_      in          req_word_type   req_valid / req_ready
//   rsp_      out         rsp_word_type   rsp_valid / rsp_ready
//
// An insert into a list holding n entries (0 < n < LIST_DEPTH) walks from the
// back of the list, one RAM read and one RAM write per cycle, moving each
// larger-or-equal entry up by one place. An insert into an empty or full list,
// a clear and an undefined code go straight to the reply. A drain of n entries
// gives one word per cycle, while the response register is free to take it,
// from the RAM's single read port.
// Reset is synchronous and empties the list; the RAM contents are not
// cleared, since only entries below the count are ever used.
// The response register lets a finished word wait while the controller
// returns to idle and takes the next request; a stalled drain simply holds
// its read address until the word is taken.
//
module sorted_insert_list_unit
   import sil_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data
);

   // -------------------------------------------------------------------------
   // Registers
   // -------------------------------------------------------------------------
   state_type              state_ff, state_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [IDX_BITS-1:0]    walk_ff, walk_in;
   logic signed [KEY_BITS-1:0] op_key_ff, op_key_in;
   logic [TAG_W-1:0]       op_tag_ff, op_tag_in;
   logic                   rep_empty_ff, rep_empty_in;
   logic                   rep_ovf_ff, rep_ovf_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_word_type           rsp_data_ff, rsp_data_in;

   // Entry store: one write port, one read port with registered data.
   entry_type              entry_mem [LIST_DEPTH];
   entry_type              rd_data_ff;
   logic [IDX_BITS-1:0]    rd_addr;
   logic                   mem_we;
   logic [IDX_BITS-1:0]    mem_waddr;
   entry_type              mem_wdata;

   // -------------------------------------------------------------------------
   // Decoded conditions
   // -------------------------------------------------------------------------
   logic req_fire;
   logic slot_free;
   logic list_full;
   logic list_none;
   logic stored_less;
   logic drain_last;
   logic rsp_load;
   logic [IDX_BITS-1:0] last_idx;

   assign req_fire    = req_valid && req_ready;
   // The response register can take a new word when it is empty or its
   // current word leaves in this cycle.
   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign list_full   = (count_ff >= COUNT_BITS'(LIST_DEPTH));
   assign list_none   = (count_ff == '0);
   assign last_idx    = IDX_BITS'(count_ff - COUNT_BITS'(1));
   // The stored entry stays below the new one only when strictly smaller,
   // which places the newest entry first among equal keys.
   assign stored_less = (rd_data_ff.key < op_key_ff);
   assign drain_last  = ((COUNT_BITS'(walk_ff) + COUNT_BITS'(1)) == count_ff);

   // -------------------------------------------------------------------------
   // Next state
   // -------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               priority if (req_data.opcode == OP_INSERT && !list_full && !list_none) begin
                  state_in = ST_WALK;
               end else if (req_data.opcode == OP_DRAIN && !list_none) begin
                  state_in = ST_DRAIN;
               end else begin
                  state_in = ST_REPLY;
               end
            end
         end
         ST_WALK: begin
            priority if (stored_less) begin
               state_in = ST_REPLY;
            end else if (walk_ff == '0) begin
               state_in = ST_HEAD;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_HEAD: begin
            state_in = ST_REPLY;
         end
         ST_DRAIN: begin
            if (slot_free && drain_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_REPLY: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // -------------------------------------------------------------------------
   // Outputs of the controller: handshake, RAM port and response load
   // -------------------------------------------------------------------------
   always_comb begin
      req_ready   = 1'b0;
      rd_addr     = walk_ff;
      mem_we      = 1'b0;
      mem_waddr   = '0;
      mem_wdata   = '{key: op_key_ff, tag: op_tag_ff};
      rsp_load    = 1'b0;
      rsp_data_in = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            // Prefetch the entry the coming operation looks at first: the
            // front for a drain, the back for an insert.
            rd_addr   = (req_data.opcode == OP_DRAIN) ? '0 : last_idx;
            // An insert into an empty list goes straight to the front.
            if (req_fire && req_data.opcode == OP_INSERT && list_none) begin
               mem_we    = 1'b1;
               mem_waddr = '0;
               mem_wdata = '{key: req_data.sort_key, tag: req_data.entry_tag};
            end
         end
         ST_WALK: begin
            // The read runs two places below the write, so the two never meet.
            rd_addr   = walk_ff - IDX_BITS'(1);
            mem_we    = 1'b1;
            mem_waddr = walk_ff + IDX_BITS'(1);
            mem_wdata = stored_less ? entry_type'{key: op_key_ff, tag: op_tag_ff}
                                    : rd_data_ff;
         end
         ST_HEAD: begin
            mem_we    = 1'b1;
            mem_waddr = '0;
         end
         ST_DRAIN: begin
            rsp_load = slot_free;
            rd_addr  = slot_free ? walk_ff + IDX_BITS'(1) : walk_ff;
            rsp_data_in = '{out_key:     rd_data_ff.key,
                            out_tag:     rd_data_ff.tag,
                            is_last:     drain_last,
                            list_empty:  1'b0,
                            overflow:    1'b0,
                            entry_count: count_ff};
         end
         ST_REPLY: begin
            rsp_load    = slot_free;
            rsp_data_in = '{out_key:     '0,
                            out_tag:     '0,
                            is_last:     1'b1,
                            list_empty:  rep_empty_ff,
                            overflow:    rep_ovf_ff,
                            entry_count: count_ff};
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   // -------------------------------------------------------------------------
   // Datapath register updates
   // -------------------------------------------------------------------------
   always_comb begin
      count_in     = count_ff;
      walk_in      = walk_ff;
      op_key_in    = op_key_ff;
      op_tag_in    = op_tag_ff;
      rep_empty_in = rep_empty_ff;
      rep_ovf_in   = rep_ovf_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_key_in    = req_data.sort_key;
               op_tag_in    = req_data.entry_tag;
               walk_in      = (req_data.opcode == OP_DRAIN) ? '0 : last_idx;
               rep_empty_in = (req_data.opcode == OP_DRAIN) && list_none;
               rep_ovf_in   = (req_data.opcode == OP_INSERT) && list_full;
               if (req_data.opcode == OP_INSERT && !list_full) begin
                  count_in = count_ff + COUNT_BITS'(1);
               end else if (req_data.opcode == OP_CLEAR) begin
                  count_in = '0;
               end
            end
         end
         ST_WALK: begin
            walk_in = walk_ff - IDX_BITS'(1);
         end
         ST_DRAIN: begin
            if (slot_free) begin
               walk_in = walk_ff + IDX_BITS'(1);
            end
         end
         ST_HEAD, ST_REPLY: begin
            walk_in = walk_ff;
         end
         default: begin
            walk_in = walk_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff      <= walk_in;
      op_key_ff    <= op_key_in;
      op_tag_ff    <= op_tag_in;
      rep_empty_ff <= rep_empty_in;
      rep_ovf_ff   <= rep_ovf_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Entry store write and registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
